// ----- sv/mre_pkg.sv -----
// ---------------------------------------------------------------------------
// mre_pkg: shared types and constants of the mask run extractor
// Register indexes, configuration bundle and the per-byte run record.
// ---------------------------------------------------------------------------
package mre_pkg;

   localparam int MaxRowPixels = 4096;
   localparam int MaxRuns      = 4;
   localparam int ColW         = 13;
   localparam int CoordW       = 16;
   localparam int MaskW        = 8;
   localparam int CsrIndexW    = 3;

   typedef enum logic [CsrIndexW-1:0] {
      REG_BLIT_WIDTH  = 3'd0,
      REG_BLIT_HEIGHT = 3'd1,
      REG_SOURCE_LEFT = 3'd2,
      REG_SOURCE_TOP  = 3'd3,
      REG_TARGET_LEFT = 3'd4,
      REG_TARGET_TOP  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [ColW-1:0]   blit_width;
      logic [ColW-1:0]   blit_height;
      logic [CoordW-1:0] source_left;
      logic [CoordW-1:0] source_top;
      logic [CoordW-1:0] target_left;
      logic [CoordW-1:0] target_top;
   } cfg_type;

   // one closed run: first column and pixel count
   typedef struct packed {
      logic [ColW-1:0] start;
      logic [ColW-1:0] length;
   } run_type;

   // up to MaxRuns runs closed by one mask byte
   typedef struct packed {
      logic [2:0]                count;
      logic [ColW-1:0]           row;
      run_type [MaxRuns-1:0]     runs;
   } entry_type;

endpackage

// ----- sv/mre_req_if.sv -----
// ---------------------------------------------------------------------------
// mre_req_if: mask byte input channel
// Valid/ready channel carrying one mask byte per item.
// ---------------------------------------------------------------------------
interface mre_req_if;
   logic                       valid;
   logic                       ready;
   logic [mre_pkg::MaskW-1:0]  mask_byte;

   modport source (output valid, output mask_byte, input ready);
   modport sink   (input valid, input mask_byte, output ready);
endinterface

// ----- sv/mre_rsp_if.sv -----
// ---------------------------------------------------------------------------
// mre_rsp_if: run output channel
// Valid/ready channel carrying one visible run per item.
// ---------------------------------------------------------------------------
interface mre_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [mre_pkg::CoordW-1:0] run_source_x;
   logic signed [mre_pkg::CoordW-1:0] run_source_y;
   logic signed [mre_pkg::CoordW-1:0] run_target_x;
   logic signed [mre_pkg::CoordW-1:0] run_target_y;
   logic [mre_pkg::ColW-1:0]          run_length;
   logic                              last_of_byte;

   modport source (output valid, output run_source_x, output run_source_y,
                   output run_target_x, output run_target_y, output run_length,
                   output last_of_byte, input ready);
   modport sink   (input valid, input run_source_x, input run_source_y,
                   input run_target_x, input run_target_y, input run_length,
                   input last_of_byte, output ready);
endinterface

// ----- sv/mre_csr_if.sv -----
// ---------------------------------------------------------------------------
// mre_csr_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface mre_csr_if;
   logic                           valid;
   logic                           ready;
   logic [mre_pkg::CsrIndexW-1:0]  index;
   logic [mre_pkg::CoordW-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/mre_csr.sv -----
// ---------------------------------------------------------------------------
// mre_csr: configuration register bank
// Holds the six blit registers and flags a scan restart on a write to any of them.
// ---------------------------------------------------------------------------
module mre_csr (
   input  logic              clock,
   input  logic              reset,
   mre_csr_if.sink           csr_ch,
   output mre_pkg::cfg_type  cfg,
   output logic              restart
);

   mre_pkg::cfg_type cfg_ff, cfg_in;
   logic             hit;
   logic             wr;

   assign csr_ch.ready = 1'b1;
   assign wr           = csr_ch.valid;

   // decode the write
   always_comb begin
      cfg_in = cfg_ff;
      hit    = 1'b0;
      if (wr) begin
         unique case (csr_ch.index)
            mre_pkg::REG_BLIT_WIDTH: begin
               cfg_in.blit_width = csr_ch.data[mre_pkg::ColW-1:0];
               hit = 1'b1;
            end
            mre_pkg::REG_BLIT_HEIGHT: begin
               cfg_in.blit_height = csr_ch.data[mre_pkg::ColW-1:0];
               hit = 1'b1;
            end
            mre_pkg::REG_SOURCE_LEFT: begin
               cfg_in.source_left = csr_ch.data;
               hit = 1'b1;
            end
            mre_pkg::REG_SOURCE_TOP: begin
               cfg_in.source_top = csr_ch.data;
               hit = 1'b1;
            end
            mre_pkg::REG_TARGET_LEFT: begin
               cfg_in.target_left = csr_ch.data;
               hit = 1'b1;
            end
            mre_pkg::REG_TARGET_TOP: begin
               cfg_in.target_top = csr_ch.data;
               hit = 1'b1;
            end
            default: hit = 1'b0;
         endcase
      end
   end

   // hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{blit_width: mre_pkg::ColW'(1), blit_height: mre_pkg::ColW'(1),
                     default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg     = cfg_ff;
   assign restart = hit;

endmodule

// ----- sv/mre_front.sv -----
// ---------------------------------------------------------------------------
// mre_front: mask byte classifier
// Walks the eight bits of an accepted byte against the scan position and
// the open run, and packs up to MaxRuns runs the byte closes into one queue entry.
// ---------------------------------------------------------------------------
module mre_front (
   input  logic                clock,
   input  logic                reset,
   mre_req_if.sink             req_ch,
   input  mre_pkg::cfg_type    cfg,
   input  logic                restart,
   input  logic                q_full,
   output logic                q_push,
   output mre_pkg::entry_type  q_entry
);

   localparam int W = mre_pkg::ColW;

   logic [W-1:0] col_ff, col_in;
   logic [W-1:0] row_ff, row_in;
   logic [W-1:0] start_ff, start_in;
   logic [W-1:0] len_ff, len_in;

   logic [W-1:0]        w_v, h_v, col_v, row_v, left_v, start_v, len_v, row_nx;
   logic [2:0]          cnt_v;
   logic                end_row;
   mre_pkg::entry_type  entry_v;

   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;

   // scan one byte
   always_comb begin
      // clamp geometry
      w_v = cfg.blit_width;
      if (w_v == '0) begin
         w_v = W'(1);
      end else if (w_v > W'(mre_pkg::MaxRowPixels)) begin
         w_v = W'(mre_pkg::MaxRowPixels);
      end
      h_v = (cfg.blit_height == '0) ? W'(1) : cfg.blit_height;
      col_v = (col_ff >= w_v) ? '0 : col_ff;
      row_v = (row_ff >= h_v) ? '0 : row_ff;
      left_v  = w_v - col_v;
      start_v = start_ff;
      len_v   = len_ff;
      cnt_v   = '0;
      entry_v = '0;

      // walk the bits, MSB first
      for (int i = 0; i < mre_pkg::MaskW; i++) begin
         if (left_v > W'(i)) begin
            if (req_ch.mask_byte[3'(mre_pkg::MaskW - 1 - i)]) begin
               if (len_v == '0) begin
                  start_v = col_v + W'(i);
               end
               len_v = len_v + W'(1);
            end else begin
               if (len_v != '0 && cnt_v < 3'(mre_pkg::MaxRuns)) begin
                  entry_v.runs[cnt_v[1:0]].start  = start_v;
                  entry_v.runs[cnt_v[1:0]].length = len_v;
                  cnt_v = cnt_v + 3'd1;
               end
               len_v   = '0;
               start_v = '0;
            end
         end
      end

      // close the run at the end of a row
      end_row = (left_v <= W'(mre_pkg::MaskW));
      if (end_row) begin
         if (len_v != '0 && cnt_v < 3'(mre_pkg::MaxRuns)) begin
            entry_v.runs[cnt_v[1:0]].start  = start_v;
            entry_v.runs[cnt_v[1:0]].length = len_v;
            cnt_v = cnt_v + 3'd1;
         end
         len_v   = '0;
         start_v = '0;
      end
      entry_v.count = cnt_v;
      entry_v.row   = row_v;

      // advance the position
      row_nx = row_v + W'(1);
      if (row_nx >= h_v) begin
         row_nx = '0;
      end
      col_in   = end_row ? '0 : col_v + W'(mre_pkg::MaskW);
      row_in   = end_row ? row_nx : row_v;
      start_in = start_v;
      len_in   = len_v;
   end

   assign q_entry = entry_v;

   // hold the scan state
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff   <= '0;
         row_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
      end else if (q_push) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         start_ff <= start_in;
         len_ff   <= len_in;
      end
   end

endmodule

// ----- sv/mre_queue.sv -----
// ---------------------------------------------------------------------------
// mre_queue: two-entry queue between front and back
// Lets the classifier run ahead while the back drains a multi-run byte.
// ---------------------------------------------------------------------------
module mre_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mre_pkg::entry_type  push_entry,
   input  logic                pop,
   output mre_pkg::entry_type  head,
   output logic                empty,
   output logic                full
);

   mre_pkg::entry_type mem_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'd2);
   assign head  = mem_ff[rd_ptr_ff];

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- sv/mre_back.sv -----
// ---------------------------------------------------------------------------
// mre_back: run emitter
// Issues the head entry's runs one per cycle into the output register while
// it is free, adding source/target offsets; entries with no run are dropped.
// ---------------------------------------------------------------------------
module mre_back (
   input  logic                clock,
   input  logic                reset,
   input  mre_pkg::cfg_type    cfg,
   input  mre_pkg::entry_type  head,
   input  logic                empty,
   output logic                pop,
   mre_rsp_if.source           rsp_ch
);

   localparam int CW = mre_pkg::CoordW;

   logic [1:0]          idx_ff, idx_in;
   logic                valid_ff, valid_in;
   logic [CW-1:0]       src_x_ff, src_y_ff, tgt_x_ff, tgt_y_ff;
   logic [CW-1:0]       src_x_in, src_y_in, tgt_x_in, tgt_y_in;
   logic [mre_pkg::ColW-1:0] len_ff, len_in;
   logic                last_ff, last_in;
   logic                out_free, load, last_run;
   logic [2:0]          cnt_m1;
   mre_pkg::run_type    run_v;

   assign out_free = !valid_ff || rsp_ch.ready;
   assign cnt_m1   = head.count - 3'd1;
   assign last_run = (idx_ff == cnt_m1[1:0]);
   assign run_v    = head.runs[idx_ff];
   assign load     = !empty && head.count != '0 && out_free;

   // pick the next run and offset it
   always_comb begin
      pop      = 1'b0;
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ch.ready;
      if (!empty && head.count == '0) begin
         pop = 1'b1;
      end else if (load) begin
         valid_in = 1'b1;
         if (last_run) begin
            pop    = 1'b1;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      src_x_in = cfg.source_left + CW'(run_v.start);
      src_y_in = cfg.source_top + CW'(head.row);
      tgt_x_in = cfg.target_left + CW'(run_v.start);
      tgt_y_in = cfg.target_top + CW'(head.row);
      len_in   = run_v.length;
      last_in  = last_run;
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // load the output register
   always_ff @(posedge clock) begin
      if (load) begin
         src_x_ff <= src_x_in;
         src_y_ff <= src_y_in;
         tgt_x_ff <= tgt_x_in;
         tgt_y_ff <= tgt_y_in;
         len_ff   <= len_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.run_source_x = src_x_ff;
   assign rsp_ch.run_source_y = src_y_ff;
   assign rsp_ch.run_target_x = tgt_x_ff;
   assign rsp_ch.run_target_y = tgt_y_ff;
   assign rsp_ch.run_length   = len_ff;
   assign rsp_ch.last_of_byte = last_ff;

endmodule

// ----- sv/mask_run_extractor_top.sv -----
// ---------------------------------------------------------------------------
// mask_run_extractor_top: transparent blit mask span extraction
// Path: an accepted byte's entry is written into the queue, and its first
// run then moves from the queue head into the output register for rsp_ch.
// Throughput: one byte per cycle while each byte closes at most one run and
// rsp_ch.ready is high; a byte closing more runs holds the single output
// register, and the two-entry queue absorbs that before req_ch.ready drops.
// Reset: synchronous; scan restarts at row 0, column 0, width and height 1,
// offsets 0, queue and output empty.
// ---------------------------------------------------------------------------
module mask_run_extractor_top (
   input  logic     clock,
   input  logic     reset,
   mre_req_if.sink  req_ch,
   mre_rsp_if.source rsp_ch,
   mre_csr_if.sink  csr_ch
);

   mre_pkg::cfg_type    cfg;
   mre_pkg::entry_type  q_entry, q_head;
   logic                restart, q_push, q_pop, q_empty, q_full;

   // configuration registers
   mre_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_ch  (csr_ch),
      .cfg     (cfg),
      .restart (restart)
   );

   // classify incoming bytes
   mre_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .cfg     (cfg),
      .restart (restart),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_entry)
   );

   // decouple front and back
   mre_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   // emit runs
   mre_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .head   (q_head),
      .empty  (q_empty),
      .pop    (q_pop),
      .rsp_ch (rsp_ch)
   );

endmodule
